@@ hdl/sbda_pkg.sv @@
package sbda_pkg;

    localparam int VAL_W      = 64;
    localparam int NUM_DIGITS = 19;              // 2^63 has 19 decimal digits
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = 7;               // holds VAL_W itself
    localparam int IDX_W      = 5;               // digit index 0..NUM_DIGITS-1
    localparam int CODE_W     = 7;

    localparam logic [CODE_W-1:0] CODE_ZERO  = 7'd48;
    localparam logic [CODE_W-1:0] CODE_NINE  = 7'd57;
    localparam logic [CODE_W-1:0] CODE_MINUS = 7'd45;

    typedef logic [VAL_W-1:0]  mag_t;
    typedef logic [BCD_W-1:0]  bcd_t;
    typedef logic [3:0]        digit_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CODE_W-1:0] code_t;

endpackage

@@ hdl/sbda_dabble.sv @@
// Shift-and-add-3 binary to BCD, one magnitude bit per cycle, MSB first.
module sbda_dabble (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  sbda_pkg::mag_t mag,
    output logic          done,
    output sbda_pkg::bcd_t bcd
);
    import sbda_pkg::*;

    mag_t             bin_reg,  bin_next;
    bcd_t             bcd_reg,  bcd_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             run_reg,  run_next;
    logic             done_reg, done_next;
    bcd_t             adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        digit_t d;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            d = bcd_reg[i*4 +: 4];
            adj[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (load)
        begin
            bin_next = mag;
            bcd_next = '0;
            cnt_next = CNT_W'(VAL_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            bcd_next = {adj[BCD_W-2:0], bin_reg[VAL_W-1]};
            bin_next = {bin_reg[VAL_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

@@ hdl/signed_binary_to_decimal_ascii.sv @@
// The first character strobes after the bit-serial BCD conversion completes.
// busy stays high through conversion until the last of the N characters (1..20)
// strobes, so a new value is taken only once the previous one is fully out; the 64-step
// bit-serial BCD conversion sets most of that wait.
// Characters come one per cycle on consecutive cycles; the receiver cannot stall.
// Reset (rst_n, async, active low) drops busy and char_valid, abandoning any
// value in progress.
module signed_binary_to_decimal_ascii (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [63:0]   value,
    output logic                 char_valid,
    output sbda_pkg::code_t      char_code,
    output logic                 last_char
);
    import sbda_pkg::*;

    // controller states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       minus_reg, minus_next;     // minus sign still to send
    idx_t       idx_reg,   idx_next;       // digit being sent, counts down to 0
    logic       cv_reg,    cv_next;
    code_t      code_reg,  code_next;
    logic       last_reg,  last_next;

    logic  accept;
    mag_t  value_u;
    mag_t  mag;
    logic  dab_done;
    bcd_t  dab_bcd;
    idx_t  top_idx;
    digit_t cur_digit;

    assign accept  = start && (state_reg == ST_IDLE);
    assign value_u = value;
    // two's complement magnitude; the most negative value gives 2^63 unsigned
    assign mag     = value_u[VAL_W-1] ? (~value_u + mag_t'(1)) : value_u;

    sbda_dabble u_dabble (
        .clk  (clk),
        .rst_n(rst_n),
        .load (accept),
        .mag  (mag),
        .done (dab_done),
        .bcd  (dab_bcd)
    );

    // highest nonzero digit; zero falls back to digit 0 so "0" is sent
    always_comb
    begin
        top_idx = '0;
        for (int i = 1; i < NUM_DIGITS; i++)
        begin
            if (dab_bcd[i*4 +: 4] != 4'd0)
            begin
                top_idx = IDX_W'(i);
            end
        end
    end

    // BCD stays put in the converter until the next load
    assign cur_digit = dab_bcd[{idx_reg, 2'b00} +: 4];

    always_comb
    begin
        state_next = state_reg;
        minus_next = minus_reg;
        idx_next   = idx_reg;
        cv_next    = 1'b0;
        code_next  = code_reg;
        last_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    minus_next = value_u[VAL_W-1];
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (dab_done)
                begin
                    idx_next   = top_idx;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cv_next = 1'b1;
                if (minus_reg)
                begin
                    code_next  = CODE_MINUS;
                    minus_next = 1'b0;
                end
                else
                begin
                    code_next = CODE_ZERO + code_t'(cur_digit);
                    if (idx_reg == '0)
                    begin
                        last_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            minus_reg <= 1'b0;
            idx_reg   <= '0;
            cv_reg    <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            minus_reg <= minus_next;
            idx_reg   <= idx_next;
            cv_reg    <= cv_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign char_valid = cv_reg;
    assign char_code  = code_reg;
    assign last_char  = last_reg;

    // an accepted value keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // no character right after the final beat of a value
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && last_char) |=> !char_valid)
        else $error("character strobe right after last beat");

    // only a minus sign or a decimal digit goes out
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> (char_code == CODE_MINUS ||
                        (char_code >= CODE_ZERO && char_code <= CODE_NINE)))
        else $error("character code out of range");

    // the sign never ends a number
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && char_code == CODE_MINUS) |-> !last_char)
        else $error("minus sign marked last");

    // conversion finishes only while the controller waits for it
    a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        dab_done |-> (state_reg == ST_CONV))
        else $error("converter done outside conversion");

endmodule

@@ bench/signed_binary_to_decimal_ascii_tb.sv @@
`timescale 1ns / 100ps

module signed_binary_to_decimal_ascii_tb;
    import sbda_pkg::*;

    // Idle cycles with no beat in or out before the run is declared hung.
    // The longest legal quiet stretch runs from accept to the first char.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 200;
    localparam int DRAIN_CYCLES   = 100;  // one full value plus margin
    localparam int PAUSE_EVERY    = 64;   // sender drains the block this often

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [63:0] value;
    logic               char_valid;
    code_t              char_code;
    logic               last_char;

    // One expected output beat: a character and its end-of-number flag.
    typedef struct packed {
        code_t code;
        logic  last;
    } char_beat_t;

    // Holds the expected text of every accepted value, in output order.
    class char_scoreboard;
        char_beat_t pending_chars[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction

        // Work out the decimal text of v and queue its characters.
        function void note_value(logic [63:0] v);
            bit [63:0]  mag;
            bit [3:0]   digs [NUM_DIGITS];
            int         n;
            char_beat_t beat;
            // Two's complement negate; the most negative value wraps to 2^63,
            // which is still correct as an unsigned magnitude.
            mag = v[63] ? (~v + 64'd1) : v;
            n = 0;
            do
            begin
                digs[n] = 4'(mag % 64'd10);
                mag = mag / 64'd10;
                n++;
            end
            while (mag != 64'd0 && n < NUM_DIGITS);
            if (v[63])
            begin
                beat.code = CODE_MINUS;
                beat.last = 1'b0;
                pending_chars.push_back(beat);
            end
            for (int k = n - 1; k >= 0; k--)
            begin
                beat.code = CODE_ZERO + code_t'(digs[k]);
                beat.last = (k == 0);
                pending_chars.push_back(beat);
            end
        endfunction

        // Compare one output beat with the oldest expected character.
        function void check_char(code_t code, logic last);
            char_beat_t want;
            if (pending_chars.size() == 0)
            begin
                $error("unexpected char beat: char_code %0d last_char %0b", code, last);
                errors++;
                return;
            end
            want = pending_chars.pop_front();
            if (code !== want.code)
            begin
                $error("char_code mismatch: expected %0d, actual %0d", want.code, code);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last_char mismatch: expected %0b, actual %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    char_scoreboard sb = new();

    signed_binary_to_decimal_ascii uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .char_valid (char_valid),
        .char_code  (char_code),
        .last_char  (last_char)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Monitors sample at the rising edge, before the block's own updates land,
    // so both see the values that the edge actually captures.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_value(value);
        if (rst_n && char_valid === 1'b1)
            sb.check_char(char_code, last_char);
    end

    // Watchdog: any input or output beat resets the count.
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || char_valid === 1'b1)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("signed_binary_to_decimal_ascii_tb: done, errors");
                $finish;
            end
        end
    end

    // Present one value after a random gap and hold it until the block takes it.
    // With a zero gap start stays high from the previous beat, so it only gets
    // one assignment per edge.
    task automatic send_value(input logic [63:0] v);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stop sending and wait until every queued character has come out.
    task automatic drain_block();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Random value: either any 64-bit pattern or one of at most a chosen digit count,
    // so short and long texts both show up often.
    function automatic logic [63:0] random_value();
        bit [63:0] raw;
        bit [63:0] limit;
        int        ndig;
        raw = {$urandom(), $urandom()};
        if ($urandom_range(0, 3) == 0)
            return raw;
        ndig = $urandom_range(1, 18);
        limit = 64'd1;
        repeat (ndig) limit = limit * 64'd10;
        raw = raw % limit;
        return $urandom_range(0, 1) ? -raw : raw;
    endfunction

    // Directed cases: zero, single digits, digit-count boundaries, both
    // extremes, and the most negative value with its unnegatable magnitude.
    logic [63:0] directed_values [] = '{
        64'd0,
        64'd1,
        -64'sd1,
        64'd9,
        -64'sd9,
        64'd10,
        -64'sd10,
        64'd99,
        64'd100,
        -64'sd100,
        64'd999999999999999999,
        64'd1000000000000000000,
        -64'sd1000000000000000000,
        64'd1234567890123456789,
        -64'sd987654321098765432,
        64'h7FFF_FFFF_FFFF_FFFF,
        64'h8000_0000_0000_0000,
        64'h8000_0000_0000_0001,
        64'h0000_0000_8000_0000,
        64'hFFFF_FFFF_7FFF_FFFF,
        64'h5555_5555_5555_5555,
        64'hAAAA_AAAA_AAAA_AAAA
    };

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        value = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_values[i])
            send_value(directed_values[i]);

        // Sender holds off here until the block has emptied out.
        drain_block();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            send_value(random_value());
            if (i % PAUSE_EVERY == PAUSE_EVERY - 1)
                drain_block();
        end

        drain_block();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
        begin
            $error("%0d expected char beats never arrived", sb.pending());
            sb.errors++;
        end

        if (sb.errors == 0)
            $display("signed_binary_to_decimal_ascii_tb: done, clean");
        else
            $display("signed_binary_to_decimal_ascii_tb: done, errors");
        $finish;
    end

endmodule
